[hw/rtl/generational_handle_allocator_defines.svh]
// Assertion macros for the generational handle allocator checker.
// Expects signals named clock and reset in the scope of use.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HGA_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HGA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/hga_pkg.sv]
// Shared codes and types of the generational handle allocator.
// No dependencies.
package hga_pkg;

   localparam logic [2:0] REQ_ACQUIRE = 3'd0;
   localparam logic [2:0] REQ_RELEASE = 3'd1;
   localparam logic [2:0] REQ_CHECK   = 3'd2;
   localparam logic [2:0] REQ_LOOKUP  = 3'd3;
   localparam logic [2:0] REQ_CLEAR   = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] out_slot;
      logic [7:0] out_generation;
      logic [7:0] dense_index;
      logic       is_valid;
      logic [8:0] live_count;
   } rsp_type;

   typedef struct packed {
      logic std;
      logic dts;
      logic gen;
   } mem_we_type;

endpackage

[hw/rtl/hga_cmp.sv]
// Shared magnitude/equality compare unit, reused across sequencer steps.
// Depends on nothing.
module hga_cmp #(
   parameter int W = 9
) (
   input  logic [W-1:0] cmp_a,
   input  logic [W-1:0] cmp_b,
   output logic         cmp_lt,
   output logic         cmp_eq
);

   assign cmp_lt = cmp_a < cmp_b;
   assign cmp_eq = cmp_a == cmp_b;

endmodule

[hw/rtl/hga_tables.sv]
// Slot-to-dense, dense-to-slot and generation tables; one write and
// one registered read per table each cycle. Uses hga_pkg.
module hga_tables import hga_pkg::*; #(
   parameter int MAX_SLOTS = 256,
   parameter int GEN_BITS  = 8
) (
   input  logic                                 clock,
   input  mem_we_type                           we,
   input  logic [$clog2(MAX_SLOTS)-1:0]         rd_slot_addr,
   input  logic [$clog2(MAX_SLOTS)-1:0]         rd_dense_addr,
   input  logic [$clog2(MAX_SLOTS)-1:0]         std_waddr,
   input  logic [$clog2(MAX_SLOTS+1)-1:0]       std_wdata,
   input  logic [$clog2(MAX_SLOTS)-1:0]         dts_waddr,
   input  logic [$clog2(MAX_SLOTS)-1:0]         dts_wdata,
   input  logic [$clog2(MAX_SLOTS)-1:0]         gen_waddr,
   input  logic [GEN_BITS-1:0]                  gen_wdata,
   output logic [$clog2(MAX_SLOTS+1)-1:0]       std_rdata,
   output logic [$clog2(MAX_SLOTS)-1:0]         dts_rdata,
   output logic [GEN_BITS-1:0]                  gen_rdata
);

   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);

   logic [CNT_W-1:0]    slot_dense_ff [MAX_SLOTS];
   logic [IDX_W-1:0]    dense_slot_ff [MAX_SLOTS];
   logic [GEN_BITS-1:0] slot_gen_ff   [MAX_SLOTS];

   logic [CNT_W-1:0]    std_rdata_ff;
   logic [IDX_W-1:0]    dts_rdata_ff;
   logic [GEN_BITS-1:0] gen_rdata_ff;

   always_ff @(posedge clock) begin
      if (we.std) begin
         slot_dense_ff[std_waddr] <= std_wdata;
      end
      std_rdata_ff <= slot_dense_ff[rd_slot_addr];
   end

   always_ff @(posedge clock) begin
      if (we.dts) begin
         dense_slot_ff[dts_waddr] <= dts_wdata;
      end
      dts_rdata_ff <= dense_slot_ff[rd_dense_addr];
   end

   always_ff @(posedge clock) begin
      if (we.gen) begin
         slot_gen_ff[gen_waddr] <= gen_wdata;
      end
      gen_rdata_ff <= slot_gen_ff[rd_slot_addr];
   end

   assign std_rdata = std_rdata_ff;
   assign dts_rdata = dts_rdata_ff;
   assign gen_rdata = gen_rdata_ff;

endmodule

[hw/rtl/hga_ctrl.sv]
// Sequencer of the allocator: request latch, counters, free list head,
// table access and result assembly over the shared compare unit. Uses hga_pkg.
module hga_ctrl import hga_pkg::*; #(
   parameter int MAX_SLOTS = 256,
   parameter int GEN_BITS  = 8
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  req_valid,
   output logic                                                  req_ready,
   input  logic [2:0]                                            req_type,
   input  logic [7:0]                                            req_slot_index,
   input  logic [7:0]                                            req_generation,
   input  logic                                                  out_free,
   output logic                                                  done,
   output rsp_type                                               res,
   output mem_we_type                                            we,
   output logic [$clog2(MAX_SLOTS)-1:0]                          rd_slot_addr,
   output logic [$clog2(MAX_SLOTS)-1:0]                          rd_dense_addr,
   output logic [$clog2(MAX_SLOTS)-1:0]                          std_waddr,
   output logic [$clog2(MAX_SLOTS+1)-1:0]                        std_wdata,
   output logic [$clog2(MAX_SLOTS)-1:0]                          dts_waddr,
   output logic [$clog2(MAX_SLOTS)-1:0]                          dts_wdata,
   output logic [$clog2(MAX_SLOTS)-1:0]                          gen_waddr,
   output logic [GEN_BITS-1:0]                                   gen_wdata,
   input  logic [$clog2(MAX_SLOTS+1)-1:0]                        std_rdata,
   input  logic [$clog2(MAX_SLOTS)-1:0]                          dts_rdata,
   input  logic [GEN_BITS-1:0]                                   gen_rdata,
   output logic [(($clog2(MAX_SLOTS+1) > 8) ? $clog2(MAX_SLOTS+1) : 8)-1:0] cmp_a,
   output logic [(($clog2(MAX_SLOTS+1) > 8) ? $clog2(MAX_SLOTS+1) : 8)-1:0] cmp_b,
   input  logic                                                  cmp_lt,
   input  logic                                                  cmp_eq
);

   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
   localparam logic [CNT_W-1:0] NO_SLOT = CNT_W'(MAX_SLOTS);

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_ACQ_CHK  = 11'b000_0000_0010,
      S_ACQ_POP  = 11'b000_0000_0100,
      S_ACQ_NEW  = 11'b000_0000_1000,
      S_VAL_CHK  = 11'b000_0001_0000,
      S_VAL_RD   = 11'b000_0010_0000,
      S_VAL_OWN  = 11'b000_0100_0000,
      S_REL_LAST = 11'b000_1000_0000,
      S_REL_MOVE = 11'b001_0000_0000,
      S_REL_FIN  = 11'b010_0000_0000,
      S_DONE     = 11'b100_0000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [2:0]          type_ff, type_in;
   logic [7:0]          slot_ff, slot_in;
   logic [7:0]          req_gen_ff, req_gen_in;
   logic [CNT_W-1:0]    live_ff, live_in;
   logic [CNT_W-1:0]    created_ff, created_in;
   logic [CNT_W-1:0]    free_head_ff, free_head_in;
   logic [CNT_W-1:0]    d_ff, d_in;
   logic [GEN_BITS-1:0] gen_ff, gen_in;
   rsp_type             res_ff, res_in;

   logic [CMP_W-1:0]    slot_ext;
   logic [CNT_W-1:0]    last;
   logic [CNT_W-1:0]    live_inc;
   logic [1:0]          fail_status;

   function automatic logic [GEN_BITS-1:0] next_gen(input logic [GEN_BITS-1:0] g);
      logic [GEN_BITS-1:0] n;
      n = g + 1'b1;
      if (n == '0) begin
         n = GEN_BITS'(1);
      end
      return n;
   endfunction

   assign slot_ext    = CMP_W'(slot_ff);
   assign last        = live_ff - 1'b1;
   assign live_inc    = live_ff + 1'b1;
   assign fail_status = (type_ff == REQ_CHECK) ? ST_OK : ST_INVALID;

   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      slot_in      = slot_ff;
      req_gen_in   = req_gen_ff;
      live_in      = live_ff;
      created_in   = created_ff;
      free_head_in = free_head_ff;
      d_in         = d_ff;
      gen_in       = gen_ff;
      res_in       = res_ff;
      we           = '0;
      rd_slot_addr = '0;
      rd_dense_addr = '0;
      std_waddr    = '0;
      std_wdata    = '0;
      dts_waddr    = '0;
      dts_wdata    = '0;
      gen_waddr    = '0;
      gen_wdata    = '0;
      cmp_a        = '0;
      cmp_b        = '0;
      done         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               type_in    = req_type;
               slot_in    = req_slot_index;
               req_gen_in = req_generation;
               res_in     = '0;
               res_in.live_count = 9'(live_ff);
               case (req_type)
                  REQ_ACQUIRE: begin
                     state_in = S_ACQ_CHK;
                  end
                  REQ_RELEASE, REQ_CHECK, REQ_LOOKUP: begin
                     state_in = S_VAL_CHK;
                  end
                  REQ_CLEAR: begin
                     live_in      = '0;
                     created_in   = '0;
                     free_head_in = NO_SLOT;
                     res_in.live_count = '0;
                     state_in     = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_ACQ_CHK: begin
            cmp_a        = CMP_W'(free_head_ff);
            cmp_b        = CMP_W'(NO_SLOT);
            rd_slot_addr = free_head_ff[IDX_W-1:0];
            state_in     = cmp_lt ? S_ACQ_POP : S_ACQ_NEW;
         end

         S_ACQ_POP: begin
            cmp_a        = CMP_W'(std_rdata);
            cmp_b        = CMP_W'(NO_SLOT);
            free_head_in = (!cmp_lt && !cmp_eq) ? NO_SLOT : std_rdata;
            we.std       = 1'b1;
            std_waddr    = free_head_ff[IDX_W-1:0];
            std_wdata    = live_ff;
            we.dts       = 1'b1;
            dts_waddr    = live_ff[IDX_W-1:0];
            dts_wdata    = free_head_ff[IDX_W-1:0];
            live_in      = live_inc;
            res_in.status         = ST_OK;
            res_in.out_slot       = 8'(free_head_ff);
            res_in.out_generation = 8'(gen_rdata);
            res_in.dense_index    = 8'(live_ff);
            res_in.live_count     = 9'(live_inc);
            state_in     = S_DONE;
         end

         S_ACQ_NEW: begin
            cmp_a = CMP_W'(created_ff);
            cmp_b = CMP_W'(NO_SLOT);
            if (cmp_lt) begin
               we.gen     = 1'b1;
               gen_waddr  = created_ff[IDX_W-1:0];
               gen_wdata  = GEN_BITS'(1);
               we.std     = 1'b1;
               std_waddr  = created_ff[IDX_W-1:0];
               std_wdata  = live_ff;
               we.dts     = 1'b1;
               dts_waddr  = live_ff[IDX_W-1:0];
               dts_wdata  = created_ff[IDX_W-1:0];
               live_in    = live_inc;
               created_in = created_ff + 1'b1;
               res_in.status         = ST_OK;
               res_in.out_slot       = 8'(created_ff);
               res_in.out_generation = 8'd1;
               res_in.dense_index    = 8'(live_ff);
               res_in.live_count     = 9'(live_inc);
            end else begin
               res_in.status = ST_FULL;
            end
            state_in = S_DONE;
         end

         S_VAL_CHK: begin
            cmp_a        = slot_ext;
            cmp_b        = CMP_W'(created_ff);
            rd_slot_addr = slot_ext[IDX_W-1:0];
            if (cmp_lt && req_gen_ff != '0) begin
               state_in = S_VAL_RD;
            end else begin
               res_in.status = fail_status;
               state_in      = S_DONE;
            end
         end

         S_VAL_RD: begin
            cmp_a         = CMP_W'(std_rdata);
            cmp_b         = CMP_W'(live_ff);
            d_in          = std_rdata;
            gen_in        = gen_rdata;
            rd_dense_addr = std_rdata[IDX_W-1:0];
            if (cmp_lt && gen_rdata == GEN_BITS'(req_gen_ff)) begin
               state_in = S_VAL_OWN;
            end else begin
               res_in.status = fail_status;
               state_in      = S_DONE;
            end
         end

         S_VAL_OWN: begin
            cmp_a = CMP_W'(dts_rdata);
            cmp_b = slot_ext;
            if (!cmp_eq) begin
               res_in.status = fail_status;
               state_in      = S_DONE;
            end else if (type_ff == REQ_RELEASE) begin
               state_in = S_REL_LAST;
            end else begin
               res_in.is_valid    = 1'b1;
               res_in.dense_index = 8'(d_ff);
               state_in           = S_DONE;
            end
         end

         S_REL_LAST: begin
            cmp_a         = CMP_W'(d_ff);
            cmp_b         = CMP_W'(last);
            rd_dense_addr = last[IDX_W-1:0];
            state_in      = cmp_lt ? S_REL_MOVE : S_REL_FIN;
         end

         S_REL_MOVE: begin
            we.std    = 1'b1;
            std_waddr = dts_rdata;
            std_wdata = d_ff;
            we.dts    = 1'b1;
            dts_waddr = d_ff[IDX_W-1:0];
            dts_wdata = dts_rdata;
            state_in  = S_REL_FIN;
         end

         S_REL_FIN: begin
            we.gen       = 1'b1;
            gen_waddr    = slot_ext[IDX_W-1:0];
            gen_wdata    = next_gen(gen_ff);
            we.std       = 1'b1;
            std_waddr    = slot_ext[IDX_W-1:0];
            std_wdata    = free_head_ff;
            free_head_in = CNT_W'(slot_ext);
            live_in      = last;
            res_in.is_valid    = 1'b1;
            res_in.dense_index = 8'(d_ff);
            res_in.live_count  = 9'(last);
            state_in     = S_DONE;
         end

         S_DONE: begin
            done = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         created_ff   <= '0;
         free_head_ff <= NO_SLOT;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         created_ff   <= created_in;
         free_head_ff <= free_head_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff    <= type_in;
      slot_ff    <= slot_in;
      req_gen_ff <= req_gen_in;
      d_ff       <= d_in;
      gen_ff     <= gen_in;
      res_ff     <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res       = res_ff;

endmodule

[hw/rtl/generational_handle_allocator.sv]
// Generational handle allocator (slot map), top level.
// Request channel req_*: req_type (0 acquire, 1 release, 2 check, 3 lookup,
// 4 clear), req_slot_index and req_generation form the handle for release,
// check and lookup. Response channel rsp_*: one item per request with
// status, acquired handle, dense index, liveness and live handle count.
// Both channels are valid/ready; an item moves when valid and ready are high.
// Clear and unknown types skip the table walk; acquire, check, lookup and
// release walk the tables, and a release of a live handle may also move the
// last dense entry before it frees the slot.
// One request is in flight at a time: the sequencer walks the request
// through dependent reads of single-port-read tables with registered reads
// and a single shared comparator, so the walk sets throughput: a new request
// is not taken while the sequencer still holds a result, and the next one
// can be taken in the cycle the response goes valid.
// The response sits in an output register; a new request is taken while it
// waits, and its result is held in the sequencer until rsp_ready frees it.
// Reset clears the counters and free list head; the tables are not cleared
// and the sequencer uses no entry before it has been written.
// Uses hga_pkg, hga_ctrl, hga_tables and hga_cmp.
module generational_handle_allocator import hga_pkg::*; #(
   parameter int MAX_SLOTS = 256,
   parameter int GEN_BITS  = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_type,
   input  logic [7:0] req_slot_index,
   input  logic [7:0] req_generation,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_out_slot,
   output logic [7:0] rsp_out_generation,
   output logic [7:0] rsp_dense_index,
   output logic       rsp_is_valid,
   output logic [8:0] rsp_live_count
);

   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

   mem_we_type          we;
   logic [IDX_W-1:0]    rd_slot_addr;
   logic [IDX_W-1:0]    rd_dense_addr;
   logic [IDX_W-1:0]    std_waddr;
   logic [CNT_W-1:0]    std_wdata;
   logic [IDX_W-1:0]    dts_waddr;
   logic [IDX_W-1:0]    dts_wdata;
   logic [IDX_W-1:0]    gen_waddr;
   logic [GEN_BITS-1:0] gen_wdata;
   logic [CNT_W-1:0]    std_rdata;
   logic [IDX_W-1:0]    dts_rdata;
   logic [GEN_BITS-1:0] gen_rdata;
   logic [CMP_W-1:0]    cmp_a;
   logic [CMP_W-1:0]    cmp_b;
   logic                cmp_lt;
   logic                cmp_eq;
   logic                out_free;
   logic                done;
   rsp_type             res;

   rsp_type             rsp_ff;
   logic                rsp_valid_ff;

   hga_ctrl #(
      .MAX_SLOTS (MAX_SLOTS),
      .GEN_BITS  (GEN_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_slot_index (req_slot_index),
      .req_generation (req_generation),
      .out_free       (out_free),
      .done           (done),
      .res            (res),
      .we             (we),
      .rd_slot_addr   (rd_slot_addr),
      .rd_dense_addr  (rd_dense_addr),
      .std_waddr      (std_waddr),
      .std_wdata      (std_wdata),
      .dts_waddr      (dts_waddr),
      .dts_wdata      (dts_wdata),
      .gen_waddr      (gen_waddr),
      .gen_wdata      (gen_wdata),
      .std_rdata      (std_rdata),
      .dts_rdata      (dts_rdata),
      .gen_rdata      (gen_rdata),
      .cmp_a          (cmp_a),
      .cmp_b          (cmp_b),
      .cmp_lt         (cmp_lt),
      .cmp_eq         (cmp_eq)
   );

   hga_tables #(
      .MAX_SLOTS (MAX_SLOTS),
      .GEN_BITS  (GEN_BITS)
   ) u_tables (
      .clock         (clock),
      .we            (we),
      .rd_slot_addr  (rd_slot_addr),
      .rd_dense_addr (rd_dense_addr),
      .std_waddr     (std_waddr),
      .std_wdata     (std_wdata),
      .dts_waddr     (dts_waddr),
      .dts_wdata     (dts_wdata),
      .gen_waddr     (gen_waddr),
      .gen_wdata     (gen_wdata),
      .std_rdata     (std_rdata),
      .dts_rdata     (dts_rdata),
      .gen_rdata     (gen_rdata)
   );

   hga_cmp #(
      .W (CMP_W)
   ) u_cmp (
      .cmp_a  (cmp_a),
      .cmp_b  (cmp_b),
      .cmp_lt (cmp_lt),
      .cmp_eq (cmp_eq)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_out_slot       = rsp_ff.out_slot;
   assign rsp_out_generation = rsp_ff.out_generation;
   assign rsp_dense_index    = rsp_ff.dense_index;
   assign rsp_is_valid       = rsp_ff.is_valid;
   assign rsp_live_count     = rsp_ff.live_count;

endmodule

[hw/rtl/hga_checker.sv]
// Port-level checks of the allocator, bound to the top level.
// Uses hga_pkg and generational_handle_allocator_defines.svh.
`include "generational_handle_allocator_defines.svh"

module hga_checker import hga_pkg::*; #(
   parameter int MAX_SLOTS = 256
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_out_slot,
   input logic [7:0] rsp_out_generation,
   input logic [7:0] rsp_dense_index,
   input logic       rsp_is_valid,
   input logic [8:0] rsp_live_count
);

   localparam logic [8:0] FULL_COUNT = 9'(MAX_SLOTS);

   `HGA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_live_count), "response dropped or changed while stalled")

   `HGA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request accepted while another is in flight")

   `HGA_ASSERT_IMPLIES(a_full_all_live, rsp_valid && rsp_status == ST_FULL, rsp_live_count == FULL_COUNT, "full answered with free slots left")

   `HGA_ASSERT_IMPLIES(a_error_clean, rsp_valid && rsp_status != ST_OK, !rsp_is_valid && rsp_out_slot == '0 && rsp_out_generation == '0 && rsp_dense_index == '0, "error response carries data")

endmodule

bind generational_handle_allocator hga_checker #(
   .MAX_SLOTS (MAX_SLOTS)
) u_hga_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for generational_handle_allocator: a slot map predictor,
// a queue-fed request driver with random gaps and a response monitor with random stalls.
// Depends on hga_pkg and the generational_handle_allocator RTL.
module tb_top import hga_pkg::*;;

   localparam int NO_SLOT   = 256;
   localparam int PLAN      = 0;
   localparam int SHADOW    = 1;
   localparam int LIMIT     = 500000;
   localparam int TAIL_WAIT = 16;

   localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] slot;
      logic [7:0] gen;
   } req_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_type = REQ_ACQUIRE;
   logic [7:0] req_slot_index = '0;
   logic [7:0] req_generation = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b1;
   logic [1:0] rsp_status;
   logic [7:0] rsp_out_slot;
   logic [7:0] rsp_out_generation;
   logic [7:0] rsp_dense_index;
   logic       rsp_is_valid;
   logic [8:0] rsp_live_count;

   generational_handle_allocator u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_slot_index     (req_slot_index),
      .req_generation     (req_generation),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_out_slot       (rsp_out_slot),
      .rsp_out_generation (rsp_out_generation),
      .rsp_dense_index    (rsp_dense_index),
      .rsp_is_valid       (rsp_is_valid),
      .rsp_live_count     (rsp_live_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Two copies of the table: one steers stimulus, one predicts accepted items.
   logic [8:0] dense_of_slot [2][256];
   logic [7:0] slot_of_dense [2][256];
   logic [7:0] gen_of_slot   [2][256];
   int         slot_count     [2];
   int         live_handles   [2];
   int         free_list_head [2];

   req_item_type request_backlog [$];
   rsp_type      expected_handle_rsps [$];

   int  failures = 0;
   int  cycles = 0;
   int  req_gap = 0;
   int  rsp_hold = 0;
   int  hold;
   bit  req_calm = 1'b0;
   bit  rsp_calm = 1'b0;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   req_item_type next_req;
   rsp_type      want;

   function automatic void clear_table(input int ctx);
      for (int i = 0; i < NO_SLOT; i++) begin
         dense_of_slot[ctx][i] = '0;
         slot_of_dense[ctx][i] = '0;
         gen_of_slot[ctx][i]   = '0;
      end
      slot_count[ctx]     = 0;
      live_handles[ctx]   = 0;
      free_list_head[ctx] = NO_SLOT;
   endfunction

   function automatic bit handle_is_live(input int ctx, input int slot, input logic [7:0] gen);
      int d;
      if (gen == 0 || slot >= slot_count[ctx]) return 1'b0;
      if (gen_of_slot[ctx][slot] != gen) return 1'b0;
      d = int'(dense_of_slot[ctx][slot]);
      if (d >= live_handles[ctx]) return 1'b0;
      return slot_of_dense[ctx][d] == 8'(slot);
   endfunction

   function automatic rsp_type handle_table_step(input int ctx, input req_item_type it);
      rsp_type r;
      int s, d, last, moved;
      logic [7:0] bumped;
      r = '0;
      s = int'(it.slot);
      case (it.kind)
         REQ_ACQUIRE: begin
            if (free_list_head[ctx] < NO_SLOT) begin
               s = free_list_head[ctx];
               free_list_head[ctx] = (int'(dense_of_slot[ctx][s]) > NO_SLOT)
                                     ? NO_SLOT : int'(dense_of_slot[ctx][s]);
            end else if (slot_count[ctx] < NO_SLOT) begin
               s = slot_count[ctx];
               gen_of_slot[ctx][s] = 8'd1;
               slot_count[ctx]++;
            end else begin
               r.status = ST_FULL;
            end
            if (r.status == ST_OK) begin
               dense_of_slot[ctx][s] = 9'(live_handles[ctx]);
               slot_of_dense[ctx][live_handles[ctx]] = 8'(s);
               r.out_slot       = 8'(s);
               r.out_generation = gen_of_slot[ctx][s];
               r.dense_index    = 8'(live_handles[ctx]);
               live_handles[ctx]++;
            end
         end
         REQ_RELEASE: begin
            if (handle_is_live(ctx, s, it.gen)) begin
               d = int'(dense_of_slot[ctx][s]);
               last = live_handles[ctx] - 1;
               bumped = gen_of_slot[ctx][s] + 8'd1;
               gen_of_slot[ctx][s] = (bumped == 0) ? 8'd1 : bumped;
               if (d < last) begin
                  moved = int'(slot_of_dense[ctx][last]);
                  dense_of_slot[ctx][moved] = 9'(d);
                  slot_of_dense[ctx][d] = 8'(moved);
               end
               live_handles[ctx] = last;
               dense_of_slot[ctx][s] = 9'(free_list_head[ctx]);
               free_list_head[ctx] = s;
               r.dense_index = 8'(d);
               r.is_valid = 1'b1;
            end else begin
               r.status = ST_INVALID;
            end
         end
         REQ_CHECK, REQ_LOOKUP: begin
            if (handle_is_live(ctx, s, it.gen)) begin
               r.is_valid = 1'b1;
               r.dense_index = dense_of_slot[ctx][s][7:0];
            end else if (it.kind == REQ_LOOKUP) begin
               r.status = ST_INVALID;
            end
         end
         REQ_CLEAR: clear_table(ctx);
         default: ;
      endcase
      r.live_count = 9'(live_handles[ctx]);
      return r;
   endfunction

   function automatic int draw_wait(inout bit calm);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   task automatic queue_req(input logic [2:0] kind, input int slot, input int gen);
      req_item_type it;
      it.kind = kind;
      it.slot = 8'(slot);
      it.gen  = 8'(gen);
      void'(handle_table_step(PLAN, it));
      request_backlog.insert(request_backlog.size(), it);
   endtask

   task automatic queue_on_live(input logic [2:0] kind);
      int s;
      if (live_handles[PLAN] == 0) begin
         queue_req(REQ_ACQUIRE, $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
         s = int'(slot_of_dense[PLAN][$urandom_range(0, live_handles[PLAN] - 1)]);
         queue_req(kind, s, int'(gen_of_slot[PLAN][s]));
      end
   endtask

   // Stale, zero, unknown or current-generation handles; the last may be live or on a freed slot.
   task automatic queue_on_odd(input logic [2:0] kind);
      int s, g;
      s = (slot_count[PLAN] == 0) ? $urandom_range(0, 255)
                                  : $urandom_range(0, slot_count[PLAN] - 1);
      g = int'(gen_of_slot[PLAN][s]);
      case ($urandom_range(0, 3))
         0: ;
         1: g = (g + $urandom_range(1, 255)) % 256;
         2: g = 0;
         default: begin
            s = $urandom_range(0, 255);
            g = $urandom_range(0, 255);
         end
      endcase
      queue_req(kind, s, g);
   endtask

   task automatic mixed_phase(input int n);
      int pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)      queue_req(REQ_ACQUIRE, $urandom_range(0, 255), $urandom_range(0, 255));
         else if (pick < 52) queue_on_live(REQ_RELEASE);
         else if (pick < 60) queue_on_odd(REQ_RELEASE);
         else if (pick < 70) queue_on_live(REQ_CHECK);
         else if (pick < 76) queue_on_odd(REQ_CHECK);
         else if (pick < 86) queue_on_live(REQ_LOOKUP);
         else if (pick < 92) queue_on_odd(REQ_LOOKUP);
         else if (pick < 98) queue_req(3'($urandom_range(REQ_ACQUIRE, REQ_SPARE_LAST)),
                                       $urandom_range(0, 255), $urandom_range(0, 255));
         else                queue_req(REQ_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
      end
   endtask

   task automatic fill_phase();
      int pick;
      queue_req(REQ_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
      while (slot_count[PLAN] < NO_SLOT || free_list_head[PLAN] != NO_SLOT) begin
         pick = $urandom_range(0, 99);
         if (pick < 6)
            queue_on_live((pick < 3) ? REQ_CHECK : REQ_LOOKUP);
         else if (pick < 9 && slot_count[PLAN] < NO_SLOT)
            queue_on_live(REQ_RELEASE);
         else
            queue_req(REQ_ACQUIRE, $urandom_range(0, 255), $urandom_range(0, 255));
      end
      repeat (2) queue_req(REQ_ACQUIRE, $urandom_range(0, 255), $urandom_range(0, 255));
      queue_on_live(REQ_RELEASE);
      repeat (2) queue_req(REQ_ACQUIRE, $urandom_range(0, 255), $urandom_range(0, 255));
   endtask

   // Cycle one slot through enough generations to wrap past zero.
   task automatic churn_phase(input int rounds);
      int fs, old_gen;
      if (live_handles[PLAN] == 0)
         queue_req(REQ_ACQUIRE, $urandom_range(0, 255), $urandom_range(0, 255));
      fs = int'(slot_of_dense[PLAN][$urandom_range(0, live_handles[PLAN] - 1)]);
      repeat (rounds) begin
         old_gen = int'(gen_of_slot[PLAN][fs]);
         queue_req(REQ_RELEASE, fs, old_gen);
         if ($urandom_range(0, 15) == 0)
            queue_req($urandom_range(0, 1) ? REQ_CHECK : REQ_LOOKUP, fs, old_gen);
         queue_req(REQ_ACQUIRE, $urandom_range(0, 255), $urandom_range(0, 255));
         if ($urandom_range(0, 31) == 0) begin
            queue_on_live(REQ_RELEASE);
            queue_req(REQ_ACQUIRE, $urandom_range(0, 255), $urandom_range(0, 255));
         end
      end
   endtask

   task automatic check_field(input string name, input logic [8:0] exp_v, input logic [8:0] got);
      if (exp_v !== got) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got);
         failures++;
      end
   endtask

   // Request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (request_backlog.size() != 0) begin
            next_req = request_backlog.pop_front();
            req_valid <= 1'b1;
            req_type <= next_req.kind;
            req_slot_index <= next_req.slot;
            req_generation <= next_req.gen;
            req_gap <= draw_wait(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response ready driver
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) begin
            hold = draw_wait(rsp_calm);
            rsp_ready <= (hold == 0);
            rsp_hold <= hold;
         end else if (rsp_hold != 0) begin
            rsp_ready <= (rsp_hold == 1);
            rsp_hold <= rsp_hold - 1;
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         rsp_fire <= rsp_valid && rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_handle_rsps.size() == 0) begin
               $error("response item with no request outstanding");
               failures++;
            end else begin
               want = expected_handle_rsps.pop_front();
               check_field("status", 9'(want.status), 9'(rsp_status));
               check_field("out_slot", 9'(want.out_slot), 9'(rsp_out_slot));
               check_field("out_generation", 9'(want.out_generation),
                           9'(rsp_out_generation));
               check_field("dense_index", 9'(want.dense_index), 9'(rsp_dense_index));
               check_field("is_valid", 9'(want.is_valid), 9'(rsp_is_valid));
               check_field("live_count", want.live_count, rsp_live_count);
            end
         end
         if (req_valid && req_ready)
            expected_handle_rsps.insert(expected_handle_rsps.size(),
               handle_table_step(SHADOW, {req_type, req_slot_index, req_generation}));
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      clear_table(PLAN);
      clear_table(SHADOW);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, append, move-on-release, free list reuse, spare codes, clear
      queue_req(REQ_CHECK, 0, 1);
      queue_req(REQ_LOOKUP, 0, 1);
      queue_req(REQ_RELEASE, 0, 1);
      queue_req(REQ_ACQUIRE, 0, 0);
      queue_req(REQ_ACQUIRE, 255, 255);
      queue_req(REQ_ACQUIRE, 0, 0);
      queue_req(REQ_CHECK, 1, 1);
      queue_req(REQ_LOOKUP, 2, 1);
      queue_req(REQ_CHECK, 0, 0);
      queue_req(REQ_CHECK, 255, 255);
      queue_req(REQ_RELEASE, 0, 1);
      queue_req(REQ_LOOKUP, 2, 1);
      queue_req(REQ_CHECK, 0, 2);
      queue_req(REQ_RELEASE, 0, 1);
      queue_req(REQ_RELEASE, 1, 1);
      queue_req(REQ_ACQUIRE, 0, 0);
      queue_req(REQ_ACQUIRE, 0, 0);
      queue_req(REQ_ACQUIRE, 0, 0);
      for (int k = int'(REQ_SPARE_FIRST); k <= int'(REQ_SPARE_LAST); k++)
         queue_req(3'(k), 255, 255);
      queue_req(REQ_LOOKUP, 255, 255);
      queue_req(REQ_CLEAR, 255, 255);
      queue_req(REQ_CHECK, 1, 2);
      queue_req(REQ_ACQUIRE, 0, 0);

      mixed_phase(40);
      fill_phase();
      churn_phase(256);

      while (request_backlog.size() != 0 || req_valid || expected_handle_rsps.size() != 0)
         @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (failures == 0 && expected_handle_rsps.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
